// ----- sv/dmdpt_pkg.sv -----
// Shared types and constants of the depth-preferred result table.
package dmdpt_pkg;

  // Table size; must be a power of two, the slot index is a bit slice of the key.
  localparam int SLOTS     = 65536;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int USED_W    = 17;
  localparam int USED_MAX  = 131071;

  localparam logic [1:0] OP_PROBE = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [63:0]        key;
    logic [15:0]        depth;
    logic signed [15:0] score;
    logic [1:0]         flag;
    logic [31:0]        move;
  } slot_t;

  typedef struct packed {
    logic capture;
    logic commit;
    logic sweep;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic held_clear;
  } status_t;

endpackage

// ----- sv/dmdpt_req_if.sv -----
// Request channel: one table operation per word.
interface dmdpt_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [63:0]        key;
  logic [15:0]        depth;
  logic signed [15:0] score;
  logic [1:0]         flag;
  logic [31:0]        move;

  modport source (output valid, operation, key, depth, score, flag, move, input ready);
  modport sink   (input valid, operation, key, depth, score, flag, move, output ready);
endinterface

// ----- sv/dmdpt_rsp_if.sv -----
// Response channel: one result word per request.
interface dmdpt_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic [15:0]                      found_depth;
  logic signed [15:0]               found_score;
  logic [1:0]                       found_flag;
  logic [31:0]                      found_move;
  logic                             written;
  logic [dmdpt_pkg::USED_W-1:0]     used_slots;

  modport source (output valid, hit, found_depth, found_score, found_flag, found_move,
                  written, used_slots, input ready);
  modport sink   (input valid, hit, found_depth, found_score, found_flag, found_move,
                  written, used_slots, output ready);
endinterface

// ----- sv/dmdpt_ctrl.sv -----
// Sequencer: valid-bit sweep, request capture, evaluate/commit and response valid.
module dmdpt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  input  dmdpt_pkg::status_t  status,
  output dmdpt_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EVAL
  } state_t;

  state_t state;
  logic   out_free;

  assign req_ready   = (state == ST_IDLE);
  assign out_free    = !rsp_valid || rsp_ready;
  assign cmd.capture = req_valid && req_ready;
  assign cmd.commit  = (state == ST_EVAL) && out_free;
  assign cmd.sweep   = (state == ST_SWEEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SWEEP;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_SWEEP: begin
          if (status.sweep_last) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (cmd.capture) state <= ST_EVAL;
        end
        ST_EVAL: begin
          if (out_free) state <= status.held_clear ? ST_SWEEP : ST_IDLE;
        end
        default: state <= ST_SWEEP;
      endcase
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/dmdpt_datapath.sv -----
// Slot and valid memories, compare/replace logic, usage count and result register.
module dmdpt_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  dmdpt_pkg::cmd_t               cmd,
  output dmdpt_pkg::status_t            status,
  input  logic [1:0]                    operation,
  input  logic [63:0]                   key,
  input  logic [15:0]                   depth,
  input  logic signed [15:0]            score,
  input  logic [1:0]                    flag,
  input  logic [31:0]                   move,
  output logic                          hit,
  output logic [15:0]                   found_depth,
  output logic signed [15:0]            found_score,
  output logic [1:0]                    found_flag,
  output logic [31:0]                   found_move,
  output logic                          written,
  output logic [dmdpt_pkg::USED_W-1:0]  used_slots
);

  localparam int AW     = dmdpt_pkg::SLOT_BITS;
  localparam int CW     = dmdpt_pkg::CNT_W;
  localparam int UW     = dmdpt_pkg::USED_W;
  localparam int WIDE_W = (CW > UW) ? CW : UW;

  dmdpt_pkg::slot_t slot_mem [dmdpt_pkg::SLOTS];
  logic             valid_mem [dmdpt_pkg::SLOTS];

  logic [1:0]       op_q;
  dmdpt_pkg::slot_t new_q;
  logic [AW-1:0]    idx_q;
  dmdpt_pkg::slot_t rd_entry;
  logic             rd_valid;
  logic [AW-1:0]    sweep_addr;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [WIDE_W-1:0] count_wide;
  logic [UW-1:0]    used_sat;

  dmdpt_pkg::slot_t e;
  logic             match;
  logic             replace;
  logic             is_probe;
  logic             is_store;
  logic             is_clear;
  logic             do_write;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= operation;
      new_q    <= '{key: key, depth: depth, score: score, flag: flag, move: move};
      idx_q    <= key[AW-1:0];
      rd_entry <= slot_mem[key[AW-1:0]];
      rd_valid <= valid_mem[key[AW-1:0]];
    end
  end

  assign e        = rd_valid ? rd_entry : '0;
  assign match    = (e.key == new_q.key);
  assign replace  = !match || (e.depth < new_q.depth);
  assign is_probe = (op_q == dmdpt_pkg::OP_PROBE);
  assign is_store = (op_q == dmdpt_pkg::OP_STORE);
  assign is_clear = (op_q == dmdpt_pkg::OP_CLEAR);
  assign do_write = cmd.commit && is_store && replace;

  always_ff @(posedge clk) begin
    if (do_write) slot_mem[idx_q] <= new_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      valid_mem[sweep_addr] <= 1'b0;
    end else if (do_write) begin
      valid_mem[idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.sweep) begin
      sweep_addr <= sweep_addr + AW'(1);
    end
  end

  assign status.sweep_last = (sweep_addr == AW'(dmdpt_pkg::SLOTS - 1));
  assign status.held_clear = is_clear;

  always_comb begin
    count_next = count;
    if (cmd.commit && is_clear) begin
      count_next = '0;
    end else if (do_write) begin
      if (e.key != 64'd0 && new_q.key == 64'd0) begin
        count_next = count - CW'(1);
      end else if (e.key == 64'd0 && new_q.key != 64'd0) begin
        count_next = count + CW'(1);
      end
    end
  end

  assign count_wide = WIDE_W'(count_next);
  assign used_sat   = (count_wide > WIDE_W'(dmdpt_pkg::USED_MAX)) ?
                      UW'(dmdpt_pkg::USED_MAX) : count_wide[UW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit         <= is_probe && match;
      found_depth <= (is_probe && match) ? e.depth : '0;
      found_score <= (is_probe && match) ? e.score : '0;
      found_flag  <= (is_probe && match) ? e.flag  : '0;
      found_move  <= (is_probe && match) ? e.move  : '0;
      written     <= do_write;
      used_slots  <= used_sat;
    end
  end

endmodule

// ----- sv/direct_mapped_depth_preferred_table_top.sv -----
// Top level of the direct-mapped, depth-preferred result table.
//
//   channel  role    word
//   req      sink    operation, key, depth, score, flag, move
//   rsp      source  hit, found_depth/score/flag/move, written, used_slots
//
// Probe and store: accept with a registered slot read, then the result is
// registered on commit; a new word is taken only after that result is registered.
// Clear: result registered the same way, then a sweep of all SLOTS (65536) slots of
// the valid memory, with req.ready low. The same sweep runs after reset.
// A held result stalls the next word in the evaluate step until rsp drains.
module direct_mapped_depth_preferred_table_top (
  input  logic          clk,
  input  logic          rst,
  dmdpt_req_if.sink     req,
  dmdpt_rsp_if.source   rsp
);

  dmdpt_pkg::cmd_t    cmd;
  dmdpt_pkg::status_t status;

  dmdpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  dmdpt_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .operation   (req.operation),
    .key         (req.key),
    .depth       (req.depth),
    .score       (req.score),
    .flag        (req.flag),
    .move        (req.move),
    .hit         (rsp.hit),
    .found_depth (rsp.found_depth),
    .found_score (rsp.found_score),
    .found_flag  (rsp.found_flag),
    .found_move  (rsp.found_move),
    .written     (rsp.written),
    .used_slots  (rsp.used_slots)
  );

endmodule

// ----- sv/dmdpt_checker.sv -----
// Port-level assertions for the result table, bound to the top level.
module dmdpt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic                         hit,
  input logic [15:0]                  found_depth,
  input logic                         written,
  input logic [dmdpt_pkg::USED_W-1:0] used_slots
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(used_slots) && $stable(hit))
    else $error("response word changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while one is in flight");

  a_hit_xor_write: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(hit && written) && (hit || found_depth == 16'd0))
    else $error("result mixes probe and store fields");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 32'(used_slots) <= 32'(dmdpt_pkg::SLOTS))
    else $error("used slot count exceeds table size");

endmodule

bind direct_mapped_depth_preferred_table_top dmdpt_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .hit         (rsp.hit),
  .found_depth (rsp.found_depth),
  .written     (rsp.written),
  .used_slots  (rsp.used_slots)
);
